// ===== src/stt_pkg.sv =====
package stt_pkg;

    // Width of the running byte offset; offsets and lengths wrap at this width
    localparam int OFFSET_BITS = 16;

    // Result queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DEL    = 8'hFF;

    typedef enum logic [4:0] {
        KIND_LPAREN      = 5'd0,
        KIND_RPAREN      = 5'd1,
        KIND_PLUS        = 5'd2,
        KIND_MINUS       = 5'd3,
        KIND_MULTIPLY    = 5'd4,
        KIND_DIVIDE      = 5'd5,
        KIND_SOME        = 5'd6,
        KIND_COMMA       = 5'd7,
        KIND_BANG        = 5'd8,
        KIND_NOT_EQUAL   = 5'd9,
        KIND_ASSIGN      = 5'd10,
        KIND_EQUAL       = 5'd11,
        KIND_AND         = 5'd12,
        KIND_OR          = 5'd13,
        KIND_PIPE        = 5'd14,
        KIND_COLON       = 5'd15,
        KIND_RETURN_TYPE = 5'd16,
        KIND_SEMI        = 5'd17,
        KIND_BLOCK_END   = 5'd18,
        KIND_IDEN        = 5'd19,
        KIND_INT         = 5'd20,
        KIND_STRING      = 5'd21,
        KIND_ILLEGAL     = 5'd22,
        KIND_END         = 5'd23
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDEN,
        MODE_INT,
        MODE_STR,
        MODE_DONE
    } t_mode;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_BANG,
        PEND_EQ,
        PEND_AMP,
        PEND_BAR,
        PEND_COLON,
        PEND_SEMI
    } t_pend;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [30:0] value;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic [1:0]                   count;
        t_entry [MAX_RESULTS-1:0]     ent;
    } t_push;

    // Keep the low 16 bits of an offset, zero-extending narrow offsets
    function automatic logic [15:0] out16(input logic [OFFSET_BITS-1:0] x);
        logic [31:0] t;
        t = 32'(x);
        return t[15:0];
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // Token for an operator that found no partner
    function automatic t_kind lone_kind(input t_pend p);
        t_kind k;
        case (p)
            PEND_BANG:  k = KIND_BANG;
            PEND_EQ:    k = KIND_ASSIGN;
            PEND_COLON: k = KIND_COLON;
            PEND_SEMI:  k = KIND_SEMI;
            default:    k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

// ===== src/stt_scan.sv =====
module stt_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_text_byte,
    input  logic           i_stream_end,
    output stt_pkg::t_push o_push
);
    import stt_pkg::*;

    t_mode                  r_mode, n_mode;
    t_pend                  r_pend, n_pend;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_tbeg, n_tbeg;
    logic [30:0]            r_acc, n_acc;

    t_entry [MAX_RESULTS-1:0] toks;
    logic [1:0]               cnt;
    logic                     consumed;
    logic [OFFSET_BITS-1:0]   nxt;
    logic [34:0]              acc_wide;
    t_kind                    pair_k;
    logic                     pair_hit;

    function automatic t_entry tok(input t_kind k, input logic [OFFSET_BITS-1:0] s,
                                   input logic [OFFSET_BITS-1:0] l, input logic [30:0] v);
        t_entry e;
        e.kind   = k;
        e.start  = out16(s);
        e.length = out16(l);
        e.value  = v;
        e.last   = 1'b0;
        return e;
    endfunction

    // Work out the whole step for one byte: state update and up to three tokens
    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_off    = r_off;
        n_tbeg   = r_tbeg;
        n_acc    = r_acc;
        toks     = '0;
        cnt      = 2'd0;
        consumed = 1'b0;
        nxt      = r_off + 1'b1;
        acc_wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {31'b0, i_text_byte[3:0]};
        pair_k   = KIND_ILLEGAL;
        pair_hit = 1'b0;

        // Match a two-character operator against the pending first character
        case (r_pend)
            PEND_BANG:  begin
                pair_hit = i_text_byte == CH_EQUAL;
                pair_k   = KIND_NOT_EQUAL;
            end
            PEND_EQ:    begin
                pair_hit = i_text_byte == CH_EQUAL;
                pair_k   = KIND_EQUAL;
            end
            PEND_AMP:   begin
                pair_hit = i_text_byte == CH_AMP;
                pair_k   = KIND_AND;
            end
            PEND_BAR:   begin
                pair_hit = i_text_byte == CH_BAR || i_text_byte == CH_GT;
                pair_k   = (i_text_byte == CH_BAR) ? KIND_OR : KIND_PIPE;
            end
            PEND_COLON: begin
                pair_hit = i_text_byte == CH_COLON;
                pair_k   = KIND_RETURN_TYPE;
            end
            PEND_SEMI:  begin
                pair_hit = i_text_byte == CH_SEMI;
                pair_k   = KIND_BLOCK_END;
            end
            default: ;
        endcase

        // Finish or extend the token in progress
        if (r_mode == MODE_DONE) begin
            consumed = 1'b1;
        end else if (r_pend != PEND_NONE) begin
            toks[0]  = tok(pair_hit ? pair_k : lone_kind(r_pend), r_tbeg, '0, '0);
            cnt      = 2'd1;
            consumed = pair_hit;
            n_pend   = PEND_NONE;
        end else begin
            case (r_mode)
                MODE_IDEN: begin
                    if (is_letter(i_text_byte)) begin
                        consumed = 1'b1;
                    end else begin
                        toks[0] = tok(KIND_IDEN, r_tbeg, r_off - r_tbeg, '0);
                        cnt     = 2'd1;
                        n_mode  = MODE_IDLE;
                    end
                end
                MODE_INT: begin
                    if (is_digit(i_text_byte)) begin
                        n_acc    = (acc_wide > {4'b0, INT_SAT}) ? INT_SAT : acc_wide[30:0];
                        consumed = 1'b1;
                    end else begin
                        toks[0] = tok(KIND_INT, r_tbeg, r_off - r_tbeg, r_acc);
                        cnt     = 2'd1;
                        n_mode  = MODE_IDLE;
                    end
                end
                MODE_STR: begin
                    if (i_text_byte == CH_QUOTE) begin
                        toks[0] = tok(KIND_STRING, r_tbeg, r_off - r_tbeg, '0);
                        cnt     = 2'd1;
                        n_mode  = MODE_IDLE;
                    end
                    consumed = 1'b1;
                end
                default: ;
            endcase
        end

        // Scan the byte from idle
        if (!consumed) begin
            case (i_text_byte) inside
                CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
                CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS,
                CH_STAR, CH_SLASH, CH_QUEST, CH_COMMA: begin
                    case (i_text_byte)
                        CH_LPAREN: toks[cnt] = tok(KIND_LPAREN, r_off, '0, '0);
                        CH_RPAREN: toks[cnt] = tok(KIND_RPAREN, r_off, '0, '0);
                        CH_PLUS:   toks[cnt] = tok(KIND_PLUS, r_off, '0, '0);
                        CH_MINUS:  toks[cnt] = tok(KIND_MINUS, r_off, '0, '0);
                        CH_STAR:   toks[cnt] = tok(KIND_MULTIPLY, r_off, '0, '0);
                        CH_SLASH:  toks[cnt] = tok(KIND_DIVIDE, r_off, '0, '0);
                        CH_QUEST:  toks[cnt] = tok(KIND_SOME, r_off, '0, '0);
                        default:   toks[cnt] = tok(KIND_COMMA, r_off, '0, '0);
                    endcase
                    cnt = cnt + 2'd1;
                end
                CH_BANG, CH_EQUAL, CH_AMP, CH_BAR, CH_COLON, CH_SEMI: begin
                    case (i_text_byte)
                        CH_BANG:  n_pend = PEND_BANG;
                        CH_EQUAL: n_pend = PEND_EQ;
                        CH_AMP:   n_pend = PEND_AMP;
                        CH_BAR:   n_pend = PEND_BAR;
                        CH_COLON: n_pend = PEND_COLON;
                        default:  n_pend = PEND_SEMI;
                    endcase
                    n_tbeg = r_off;
                end
                CH_NUL, CH_DEL: begin
                    toks[cnt] = tok(KIND_END, r_off, '0, '0);
                    cnt       = cnt + 2'd1;
                    n_mode    = MODE_DONE;
                end
                CH_QUOTE: begin
                    n_mode = MODE_STR;
                    n_tbeg = nxt;
                end
                default: begin
                    if (is_letter(i_text_byte)) begin
                        n_mode = MODE_IDEN;
                        n_tbeg = r_off;
                    end else if (is_digit(i_text_byte)) begin
                        n_mode = MODE_INT;
                        n_tbeg = r_off;
                        n_acc  = {27'b0, i_text_byte[3:0]};
                    end else begin
                        toks[cnt] = tok(KIND_ILLEGAL, r_off, '0, '0);
                        cnt       = cnt + 2'd1;
                    end
                end
            endcase
        end

        // Close the stream: flush what is open, add END, return to reset
        if (i_stream_end) begin
            if (n_mode != MODE_DONE) begin
                if (n_pend != PEND_NONE) begin
                    toks[cnt] = tok(lone_kind(n_pend), n_tbeg, '0, '0);
                    cnt       = cnt + 2'd1;
                end else if (n_mode == MODE_IDEN) begin
                    toks[cnt] = tok(KIND_IDEN, n_tbeg, nxt - n_tbeg, '0);
                    cnt       = cnt + 2'd1;
                end else if (n_mode == MODE_INT) begin
                    toks[cnt] = tok(KIND_INT, n_tbeg, nxt - n_tbeg, n_acc);
                    cnt       = cnt + 2'd1;
                end else if (n_mode == MODE_STR) begin
                    toks[cnt] = tok(KIND_STRING, n_tbeg, nxt - n_tbeg, '0);
                    cnt       = cnt + 2'd1;
                end
                // Drop END when three tokens are already out
                if (cnt != 2'd3) begin
                    toks[cnt] = tok(KIND_END, nxt, '0, '0);
                    cnt       = cnt + 2'd1;
                end
            end
            n_mode = MODE_IDLE;
            n_pend = PEND_NONE;
            n_off  = '0;
            n_tbeg = '0;
            n_acc  = '0;
        end else begin
            n_off = nxt;
        end

        // Mark the last token of this byte
        case (cnt)
            2'd1:    toks[0].last = 1'b1;
            2'd2:    toks[1].last = 1'b1;
            2'd3:    toks[2].last = 1'b1;
            default: ;
        endcase

        o_push.count = cnt;
        o_push.ent   = toks;
    end

    // Advance scanner state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pend <= PEND_NONE;
            r_off  <= '0;
            r_tbeg <= '0;
            r_acc  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_off  <= n_off;
            r_tbeg <= n_tbeg;
            r_acc  <= n_acc;
        end
    end

endmodule

// ===== src/stt_token_fifo.sv =====
module stt_token_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_en,
    input  stt_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output stt_pkg::t_entry o_entry
);
    import stt_pkg::*;

    localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(FIFO_DEPTH - MAX_RESULTS);

    t_entry              r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, r_rptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [1:0]          push_n;
    logic                pop;

    assign push_n  = i_push_en ? i_push.count : 2'd0;
    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_room  = r_count <= ROOM_LIMIT;
    assign o_entry = r_mem[r_rptr];
    assign n_count = r_count + CNT_BITS'(push_n) - CNT_BITS'(pop);

    // Write up to three tokens of one beat at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < push_n) begin
                r_mem[r_wptr + PTR_BITS'(i)] <= i_push.ent[i];
            end
        end
    end

    // Advance pointers and hold the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_BITS'(push_n);
            r_rptr  <= r_rptr + PTR_BITS'(pop);
            r_count <= n_count;
        end
    end

endmodule

// ===== src/source_text_tokenizer.sv =====
// Source text tokenizer: takes one source byte per beat and returns tokens one per
// beat, with the last token caused by a byte flagged in o_final_of_run. Each byte
// yields zero to three tokens, which go into an eight-entry token queue that drains
// one token per cycle while i_ready is high. o_ready is high while the queue holds
// at most five tokens, so while i_ready stays high the input runs at one byte per
// cycle as long as bytes average no more than one token each, and otherwise at the
// output rate of one token per cycle. The byte marked by i_stream_end closes the
// stream and the next byte starts a new one at offset 0.
module source_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_text_start,
    output logic [15:0] o_text_length,
    output logic [30:0] o_int_value,
    output logic        o_final_of_run
);
    import stt_pkg::*;

    t_push  push;
    t_entry head;
    logic   accept;

    assign accept = i_valid && o_ready;

    stt_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_text_byte  (i_text_byte),
        .i_stream_end (i_stream_end),
        .o_push       (push)
    );

    stt_token_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .o_room    (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_entry   (head)
    );

    // Unpack the head token onto the result ports
    assign o_token_kind   = head.kind;
    assign o_text_start   = head.start;
    assign o_text_length  = head.length;
    assign o_int_value    = head.value;
    assign o_final_of_run = head.last;

endmodule
